[sv/dlts_pkg.sv]
// Shared types and constants of the delta-list task scheduler.
package dlts_pkg;

  localparam int TASK_SLOTS = 16;
  localparam int IDX_W      = $clog2(TASK_SLOTS);
  localparam int CNT_W      = $clog2(TASK_SLOTS + 1);

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_ADD  = 2'd1,
    OP_DEL  = 2'd2,
    OP_DISP = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TICK_RD,
    S_DISP_RD,
    S_DEL_WALK,
    S_REM_SHIFT,
    S_REM_END,
    S_INS_START,
    S_ADD_WALK,
    S_ADD_SHIFT,
    S_ADD_WRITE,
    S_DONE
  } state_e;

  // One table entry as held in the slot memory
  typedef struct packed {
    logic        ready;
    logic [7:0]  handle;
    logic [31:0] delta;
    logic [31:0] period;
    logic [15:0] ident;
  } slot_t;

endpackage

[sv/delta_list_task_scheduler.sv]
// Delta-list task scheduler: sequencer around the slot memory.
// busy spans the result cycle; a new operation is taken only in idle, once busy is low.
// Every shift step is one memory read and one write, a walk step a read only; walks and shifts run one slot a cycle.
// Reset clears the fill count, the id counter and the sequencer; memory needs no clearing.
// The result is shown for one cycle on result_valid_o and cannot be stalled.
module delta_list_task_scheduler
  import dlts_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op_i,
  input  logic [7:0]  task_handle_i,
  input  logic [31:0] start_delay_i,
  input  logic [31:0] repeat_period_i,
  input  logic [15:0] target_id_i,
  output logic        result_valid_o,
  output logic [1:0]  status_o,
  output logic [15:0] assigned_id_o,
  output logic        run_valid_o,
  output logic [7:0]  run_handle_o
);

  state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [IDX_W-1:0] idx_q, idx_d, pos_q, pos_d;
  logic [15:0] idc_q, idc_d;
  logic [7:0]  hdl_q, hdl_d;
  logic [31:0] dly_q, dly_d, per_q, per_d, pre_q, pre_d, car_q, car_d;
  logic [15:0] tgt_q, tgt_d;
  logic        first_q, first_d, reins_q, reins_d;
  logic [1:0]  st_q, st_d;
  logic [15:0] aid_q, aid_d;
  logic        rv_q, rv_d;
  logic [7:0]  rh_q, rh_d;

  logic             we;
  logic [IDX_W-1:0] waddr, raddr;
  slot_t            wdata, rdata;
  logic [$bits(slot_t)-1:0] rdata_raw;

  assign rdata = slot_t'(rdata_raw);

  dlts_ram #(.WIDTH($bits(slot_t)), .DEPTH(TASK_SLOTS)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata_raw)
  );

  // state and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      idc_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idc_q   <= idc_d;
    end
  end

  // working and result registers
  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    pos_q   <= pos_d;
    hdl_q   <= hdl_d;
    dly_q   <= dly_d;
    per_q   <= per_d;
    pre_q   <= pre_d;
    car_q   <= car_d;
    tgt_q   <= tgt_d;
    first_q <= first_d;
    reins_q <= reins_d;
    st_q    <= st_d;
    aid_q   <= aid_d;
    rv_q    <= rv_d;
    rh_q    <= rh_d;
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = (state_q == S_DONE);
  assign status_o       = st_q;
  assign assigned_id_o  = aid_q;
  assign run_valid_o    = rv_q;
  assign run_handle_o   = rh_q;

  // sequencer: next state, memory access and datapath
  always_comb begin
    logic [32:0]      nxt;
    logic [15:0]      nid;
    logic [CNT_W-1:0] k1;
    slot_t            e;
    nxt = '0;
    nid = '0;
    k1  = '0;
    e   = rdata;
    state_d = state_q;
    cnt_d = cnt_q;   idc_d = idc_q;
    idx_d = idx_q;   pos_d = pos_q;
    hdl_d = hdl_q;   dly_d = dly_q;  per_d = per_q;
    pre_d = pre_q;   car_d = car_q;  tgt_d = tgt_q;
    first_d = first_q; reins_d = reins_q;
    st_d = st_q; aid_d = aid_q; rv_d = rv_q; rh_d = rh_q;
    we = 1'b0; waddr = '0; wdata = rdata; raddr = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          hdl_d = task_handle_i;
          dly_d = start_delay_i;
          per_d = repeat_period_i;
          tgt_d = target_id_i;
          reins_d = 1'b0;
          st_d = ST_OK; aid_d = '0; rv_d = 1'b0; rh_d = '0;
          idx_d = '0;
          unique case (op_e'(op_i))
            OP_TICK: state_d = (cnt_q == '0) ? S_DONE : S_TICK_RD;
            OP_ADD:  state_d = S_INS_START;
            OP_DEL: begin
              if (target_id_i == '0 || cnt_q == '0) begin
                st_d = ST_MISS;
                state_d = S_DONE;
              end else begin
                state_d = S_DEL_WALK;
              end
            end
            OP_DISP: begin
              if (cnt_q == '0) begin
                st_d = ST_MISS;
                state_d = S_DONE;
              end else begin
                state_d = S_DISP_RD;
              end
            end
            default: state_d = S_DONE;
          endcase
        end
      end

      // head count-down
      S_TICK_RD: begin
        if (!rdata.ready) begin
          if (rdata.delta != '0) e.delta = rdata.delta - 32'd1;
          if (e.delta == '0) e.ready = 1'b1;
        end
        we = 1'b1; waddr = '0; wdata = e;
        state_d = S_DONE;
      end

      // ready head goes out, then removal and, for a periodic task, reinsertion
      S_DISP_RD: begin
        if (!rdata.ready) begin
          st_d = ST_MISS;
          state_d = S_DONE;
        end else begin
          rv_d = 1'b1; rh_d = rdata.handle;
          hdl_d = rdata.handle;
          dly_d = rdata.period; per_d = rdata.period;
          reins_d = (rdata.period != '0);
          car_d = rdata.delta;
          first_d = 1'b1;
          idx_d = '0;
          raddr = IDX_W'(1);
          state_d = (cnt_q > CNT_W'(1)) ? S_REM_SHIFT : S_REM_END;
        end
      end

      // search by id, one slot a cycle
      S_DEL_WALK: begin
        k1 = CNT_W'(idx_q) + CNT_W'(1);
        if (rdata.ident == tgt_q) begin
          car_d = rdata.delta;
          first_d = 1'b1;
          raddr = IDX_W'(k1);
          state_d = (k1 < cnt_q) ? S_REM_SHIFT : S_REM_END;
        end else if (k1 < cnt_q) begin
          idx_d = IDX_W'(k1);
          raddr = IDX_W'(k1);
        end else begin
          st_d = ST_MISS;
          state_d = S_DONE;
        end
      end

      // close the gap: slot idx+1 moves down to idx
      S_REM_SHIFT: begin
        if (first_q) e.delta = rdata.delta + car_q;
        we = 1'b1; waddr = idx_q; wdata = e;
        first_d = 1'b0;
        idx_d = idx_q + IDX_W'(1);
        k1 = CNT_W'(idx_q) + CNT_W'(2);
        if (k1 < cnt_q) begin
          raddr = IDX_W'(k1);
        end else begin
          state_d = S_REM_END;
        end
      end

      S_REM_END: begin
        cnt_d = cnt_q - CNT_W'(1);
        state_d = reins_q ? S_INS_START : S_DONE;
      end

      S_INS_START: begin
        pre_d = '0;
        idx_d = '0;
        if (cnt_q == CNT_W'(TASK_SLOTS)) begin
          st_d = ST_FULL;
          aid_d = '0;
          state_d = S_DONE;
        end else if (cnt_q == '0) begin
          pos_d = '0;
          state_d = S_ADD_WRITE;
        end else begin
          raddr = '0;
          state_d = S_ADD_WALK;
        end
      end

      // walk the running sum of delays
      S_ADD_WALK: begin
        nxt = {1'b0, pre_q} + {1'b0, rdata.delta};
        k1 = CNT_W'(idx_q) + CNT_W'(1);
        if (nxt > {1'b0, dly_q}) begin
          pos_d = idx_q;
          idx_d = IDX_W'(cnt_q);
          raddr = IDX_W'(cnt_q - CNT_W'(1));
          state_d = S_ADD_SHIFT;
        end else begin
          pre_d = nxt[31:0];
          if (k1 < cnt_q) begin
            idx_d = IDX_W'(k1);
            raddr = IDX_W'(k1);
          end else begin
            pos_d = IDX_W'(cnt_q);
            state_d = S_ADD_WRITE;
          end
        end
      end

      // open a gap: slot idx-1 moves up to idx
      S_ADD_SHIFT: begin
        if (idx_q - IDX_W'(1) == pos_q) begin
          e.delta = rdata.delta + pre_q - dly_q;
          state_d = S_ADD_WRITE;
        end else begin
          raddr = idx_q - IDX_W'(2);
          idx_d = idx_q - IDX_W'(1);
        end
        we = 1'b1; waddr = idx_q; wdata = e;
      end

      S_ADD_WRITE: begin
        nid = idc_q + 16'd1;
        if (nid == '0) nid = 16'd1;
        idc_d = nid;
        e.delta  = dly_q - pre_q;
        e.ready  = (e.delta == '0);
        e.handle = hdl_q;
        e.period = per_q;
        e.ident  = nid;
        we = 1'b1; waddr = pos_q; wdata = e;
        cnt_d = cnt_q + CNT_W'(1);
        aid_d = nid;
        state_d = S_DONE;
      end

      S_DONE: state_d = S_IDLE;

      default: state_d = S_IDLE;
    endcase
  end

endmodule

[sv/dlts_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read.
module dlts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
